// ===== rtl/isc_pkg.sv =====
// types and constants shared by the insertion sorter
package isc_pkg;

	localparam int DATA_W        = 32;
	localparam int CMP_W         = 9;
	localparam int MAX_ITEMS_DEF = 32;

	localparam logic [CMP_W-1:0] CMP_MAX = '1;

	typedef struct packed {
		logic signed [DATA_W-1:0] value;
		logic                     is_last;
	} in_item_t;

	typedef struct packed {
		logic signed [DATA_W-1:0] sorted_value;
		logic [CMP_W-1:0]         comparisons;
		logic                     overflowed;
		logic                     end_of_list;
	} out_item_t;

endpackage

// ===== rtl/isc_ram.sv =====
// generic single write port ram with registered read
module isc_ram #(
	parameter int WIDTH = 32,
	parameter int DEPTH = 32
) (
	input  logic                                   clk,
	input  logic                                   we,
	input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] waddr,
	input  logic [WIDTH-1:0]                       wdata,
	input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] raddr,
	output logic [WIDTH-1:0]                       rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		rdata <= mem_q[raddr];
	end

endmodule

// ===== rtl/insertion_sort_with_comparison_count_unit.sv =====
// insertion sorter with comparison count: sequencer around one store ram and one compare
// insert: written straight into an empty store, else one S_CMP step per compare,
// plus S_PUT at entry 0; one ram read/compare/write step per cycle, next item in S_IDLE
// readout after a last beat, per result beat: ram read, output load, handshake
// arst_n clears sequencer, entry count, comparison total and overflow flag
// store contents are not reset; only entries already written are read
module insertion_sort_with_comparison_count_unit
	import isc_pkg::*;
#(
	parameter int MAX_ITEMS = MAX_ITEMS_DEF
) (
	input  logic      clk,
	input  logic      arst_n,
	input  logic      in_valid,
	output logic      in_ready,
	input  in_item_t  in_item,
	output logic      out_valid,
	input  logic      out_ready,
	output out_item_t out_item
);

	localparam int AW = (MAX_ITEMS > 1) ? $clog2(MAX_ITEMS) : 1;
	localparam int CW = $clog2(MAX_ITEMS + 1);
	localparam logic [CW-1:0] FULL = CW'(MAX_ITEMS);

	typedef enum logic [2:0] {
		S_IDLE,
		S_CMP,
		S_PUT,
		S_FETCH,
		S_LOAD,
		S_OUT
	} state_t;

	state_t                   state_q;
	logic [CW-1:0]            count_q;
	logic [CMP_W-1:0]         cmp_q;
	logic                     ovf_q;
	logic                     last_q;
	logic signed [DATA_W-1:0] v_q;
	logic [AW-1:0]            pos_q;
	logic [AW-1:0]            k_q;
	out_item_t                out_q;

	logic                     in_acc;
	logic                     less;
	logic                     fin;
	logic [CMP_W-1:0]         cmp_inc;
	logic                     ram_we;
	logic [AW-1:0]            ram_waddr;
	logic signed [DATA_W-1:0] ram_wdata;
	logic [AW-1:0]            ram_raddr;
	logic signed [DATA_W-1:0] ram_rdata;

	isc_ram #(
		.WIDTH(DATA_W),
		.DEPTH(MAX_ITEMS)
	) u_store (
		.clk   (clk),
		.we    (ram_we),
		.waddr (ram_waddr),
		.wdata (ram_wdata),
		.raddr (ram_raddr),
		.rdata (ram_rdata)
	);

	assign in_ready  = (state_q == S_IDLE);
	assign in_acc    = in_valid && in_ready;
	assign out_valid = (state_q == S_OUT);
	assign out_item  = out_q;

	// equal entry stops the walk, so equal values keep arrival order
	assign less    = v_q < ram_rdata;
	assign fin     = (CW'(k_q) + CW'(1)) == count_q;
	assign cmp_inc = (cmp_q == CMP_MAX) ? cmp_q : cmp_q + CMP_W'(1);

	always_comb begin
		ram_we    = 1'b0;
		ram_waddr = pos_q;
		ram_wdata = v_q;
		unique case (state_q)
			S_IDLE: begin
				ram_we    = in_acc && (count_q == '0);
				ram_waddr = '0;
				ram_wdata = in_item.value;
				ram_raddr = AW'(count_q - CW'(1));
			end
			S_CMP: begin
				ram_we    = 1'b1;
				ram_wdata = less ? ram_rdata : v_q;
				// next entry down, read while this one shifts up
				ram_raddr = pos_q - AW'(2);
			end
			S_PUT: begin
				ram_we    = 1'b1;
				ram_raddr = k_q;
			end
			default: begin
				ram_raddr = k_q;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			count_q <= '0;
			cmp_q   <= '0;
			ovf_q   <= 1'b0;
			last_q  <= 1'b0;
			v_q     <= '0;
			pos_q   <= '0;
			k_q     <= '0;
			out_q   <= '0;
		end else begin
			unique case (state_q)
				S_IDLE: begin
					if (in_acc) begin
						v_q    <= in_item.value;
						last_q <= in_item.is_last;
						k_q    <= '0;
						if (count_q == FULL) begin
							ovf_q <= 1'b1;
							if (in_item.is_last) begin
								state_q <= S_FETCH;
							end
						end else if (count_q == '0) begin
							count_q <= CW'(1);
							if (in_item.is_last) begin
								state_q <= S_FETCH;
							end
						end else begin
							pos_q   <= count_q[AW-1:0];
							state_q <= S_CMP;
						end
					end
				end
				S_CMP: begin
					cmp_q <= cmp_inc;
					if (less) begin
						pos_q <= pos_q - AW'(1);
						if (pos_q == AW'(1)) begin
							state_q <= S_PUT;
						end
					end else begin
						count_q <= count_q + CW'(1);
						state_q <= last_q ? S_FETCH : S_IDLE;
					end
				end
				S_PUT: begin
					count_q <= count_q + CW'(1);
					state_q <= last_q ? S_FETCH : S_IDLE;
				end
				S_FETCH: begin
					state_q <= S_LOAD;
				end
				S_LOAD: begin
					out_q.sorted_value <= ram_rdata;
					out_q.comparisons  <= fin ? cmp_q : '0;
					out_q.overflowed   <= ovf_q;
					out_q.end_of_list  <= fin;
					state_q            <= S_OUT;
				end
				S_OUT: begin
					if (out_ready) begin
						if (out_q.end_of_list) begin
							count_q <= '0;
							cmp_q   <= '0;
							ovf_q   <= 1'b0;
							state_q <= S_IDLE;
						end else begin
							k_q     <= k_q + AW'(1);
							state_q <= S_FETCH;
						end
					end
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

`ifndef NO_ASSERTIONS
	a_no_overlap: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> !in_ready)
		else $error("input taken while a result beat is pending");

	a_count_range: assert property (@(posedge clk) disable iff (!arst_n)
		count_q <= FULL)
		else $error("entry count beyond capacity");

	a_run_clears: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && out_ready && out_item.end_of_list)
		|=> (count_q == '0 && cmp_q == '0 && !ovf_q))
		else $error("state not cleared after end of list");

	a_cmp_on_end: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && !out_item.end_of_list) |-> (out_item.comparisons == '0))
		else $error("comparison total on a beat that is not the last");
`endif

endmodule

// ===== verif/insertion_sort_with_comparison_count_unit_tb.sv =====
// testbench for the insertion sorter: directed and random data sets, predicted sorted runs, beat checks
module insertion_sort_with_comparison_count_unit_tb;
	import isc_pkg::*;

	localparam int DEPTH        = MAX_ITEMS_DEF;
	localparam int STALL_LIMIT  = 4000;
	localparam int RANDOM_ITEMS = 360;
	localparam int IDLE_PCT     = 8;
	localparam logic signed [DATA_W-1:0] VMIN = {1'b1, {(DATA_W-1){1'b0}}};
	localparam logic signed [DATA_W-1:0] VMAX = {1'b0, {(DATA_W-1){1'b1}}};

	logic      clk       = 1'b0;
	logic      arst_n    = 1'b0;
	logic      in_valid  = 1'b0;
	in_item_t  in_item   = '0;
	logic      out_ready = 1'b0;
	logic      in_ready;
	logic      out_valid;
	out_item_t out_item;

	bit idle_on      = 1'b1;
	int stall_cycles = 0;

	class sort_checker;
		logic signed [DATA_W-1:0] entries [DEPTH];
		int unsigned              entry_count;
		logic [CMP_W-1:0]         cmp_total;
		logic                     dropped;
		out_item_t                expected_sorted [$];
		int                       mismatches;

		function new();
			entry_count = 0;
			cmp_total   = '0;
			dropped     = 1'b0;
			mismatches  = 0;
		endfunction

		// insert one accepted value; a last beat releases the whole sorted run
		function void take_value(in_item_t it);
			int        pos;
			out_item_t beat;
			if (entry_count < DEPTH) begin
				pos = entry_count;
				while (pos > 0) begin
					if (cmp_total != CMP_MAX)
						cmp_total++;
					if ($signed(it.value) < $signed(entries[pos-1])) begin
						entries[pos] = entries[pos-1];
						pos--;
					end else begin
						break;
					end
				end
				entries[pos] = it.value;
				entry_count++;
			end else begin
				dropped = 1'b1;
			end
			if (it.is_last) begin
				for (int k = 0; k < entry_count; k++) begin
					beat.sorted_value = entries[k];
					beat.comparisons  = (k == entry_count - 1) ? cmp_total : '0;
					beat.overflowed   = dropped;
					beat.end_of_list  = (k == entry_count - 1);
					expected_sorted.push_back(beat);
				end
				entry_count = 0;
				cmp_total   = '0;
				dropped     = 1'b0;
			end
		endfunction

		function void check_beat(out_item_t got);
			out_item_t want;
			bit        have;
			have = (expected_sorted.size() != 0);
			want = '0;
			if (have)
				want = expected_sorted.pop_front();
			if (!have || got.sorted_value !== want.sorted_value ||
				got.comparisons !== want.comparisons || got.overflowed !== want.overflowed ||
				got.end_of_list !== want.end_of_list) begin
				if (mismatches < 10) begin
					if (!have)
						$display("unexpected beat: value %0d cmp %0d ovf %0b last %0b",
							got.sorted_value, got.comparisons, got.overflowed, got.end_of_list);
					else
						$display({"mismatch: expected value %0d cmp %0d ovf %0b last %0b,",
							" got value %0d cmp %0d ovf %0b last %0b"},
							want.sorted_value, want.comparisons, want.overflowed,
							want.end_of_list, got.sorted_value, got.comparisons,
							got.overflowed, got.end_of_list);
				end
				mismatches++;
			end
		endfunction

		function int pending();
			return expected_sorted.size();
		endfunction
	endclass

	sort_checker sb = new();

	insertion_sort_with_comparison_count_unit #(.MAX_ITEMS(DEPTH)) uut (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_ready  (in_ready),
		.in_item   (in_item),
		.out_valid (out_valid),
		.out_ready (out_ready),
		.out_item  (out_item)
	);

	always begin
		#2 clk = 1'b1;
		#2 clk = 1'b0;
	end

	always @(posedge clk) begin
		out_ready <= !idle_on || ($urandom_range(99) >= IDLE_PCT);
	end

	// accepted beats on both channels, plus the watchdog
	always @(posedge clk) begin
		if (arst_n) begin
			if (in_valid && in_ready)
				sb.take_value(in_item);
			if (out_valid && out_ready)
				sb.check_beat(out_item);
			if ((in_valid && in_ready) || (out_valid && out_ready))
				stall_cycles <= 0;
			else
				stall_cycles <= stall_cycles + 1;
			if (stall_cycles >= STALL_LIMIT) begin
				$display("Simulation FAILED");
				$finish;
			end
		end
	end

	task automatic send_item(input in_item_t it);
		while (idle_on && $urandom_range(99) < IDLE_PCT) begin
			in_valid <= 1'b0;
			@(posedge clk);
		end
		in_valid <= 1'b1;
		in_item  <= it;
		do @(posedge clk); while (!in_ready);
	endtask

	task automatic send_set(input logic signed [DATA_W-1:0] vals [$]);
		for (int i = 0; i < vals.size(); i++)
			send_item(in_item_t'{value: vals[i], is_last: (i == vals.size() - 1)});
	endtask

	// hold the sender off until every sorted beat is back
	task automatic drain();
		in_valid <= 1'b0;
		// let the last accepted beat reach the checker first
		@(negedge clk);
		while (sb.pending() != 0)
			@(negedge clk);
		@(posedge clk);
	endtask

	function automatic logic signed [DATA_W-1:0] rand_value();
		case ($urandom_range(3))
			0, 1: return $urandom;
			// narrow range so equal values show up often
			2: return $signed($urandom_range(16)) - 8;
			default: begin
				case ($urandom_range(3))
					0: return VMIN;
					1: return VMAX;
					2: return -1;
					default: return 0;
				endcase
			end
		endcase
	endfunction

	initial begin
		logic signed [DATA_W-1:0] vals [$];
		int n;
		int pick;
		int sent;
		int set_no;

		repeat (10) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		vals = '{VMIN};
		send_set(vals);
		vals = '{VMAX};
		send_set(vals);
		drain();
		// descending: every insertion walks to the bottom
		vals = '{VMAX, 5, 0, -1, VMIN};
		send_set(vals);
		vals = '{VMIN, -1, 0, 5, VMAX};
		send_set(vals);
		vals = '{7, 7, -3, 7, 7};
		send_set(vals);
		vals = '{3, -9, 12, -9, 0, 12};
		send_set(vals);
		drain();

		sent   = 0;
		set_no = 0;
		while (sent < RANDOM_ITEMS) begin
			// first sets: last beat dropped on a full store, then a few dropped, then exactly full
			if (set_no == 0)
				n = DEPTH + 1;
			else if (set_no == 1)
				n = DEPTH + 3;
			else if (set_no == 2)
				n = DEPTH;
			else begin
				pick = $urandom_range(99);
				if (pick < 70)
					n = $urandom_range(8, 1);
				else if (pick < 85)
					n = $urandom_range(DEPTH - 1, 9);
				else if (pick < 93)
					n = DEPTH;
				else
					n = $urandom_range(DEPTH + 8, DEPTH + 1);
			end
			idle_on <= !(sent >= 120 && sent < 200);
			vals.delete();
			repeat (n) vals.push_back(rand_value());
			send_set(vals);
			sent += n;
			set_no++;
			if ($urandom_range(9) == 0)
				drain();
		end

		in_valid <= 1'b0;
		idle_on  <= 1'b1;
		@(negedge clk);
		while (sb.pending() != 0)
			@(negedge clk);
		repeat (40) @(posedge clk);

		if (sb.mismatches == 0 && sb.pending() == 0)
			$display("Simulation PASSED");
		else
			$display("Simulation FAILED");
		$finish;
	end

endmodule
